// ===== src/hed_pkg.sv =====
`timescale 1ns / 1ps
// Package for the HTML entity decoder: shared item and burst types, sizes,
// and the constant tables of the named entities. No dependencies.
package hed_pkg;

    // Held bytes of a pending entity, and the most result bytes one input byte can cause.
    localparam int HELD_DEPTH = 5;
    localparam int MAX_OUT    = 6;
    localparam int COUNT_W    = 3;
    localparam int ENT_COUNT  = 6;

    // One registered input transaction.
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    // All result bytes caused by one input byte, in order from slot 0.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } burst_t;

    // Character i of named entity e, after the '&' and including the ';'.
    function automatic logic [7:0] ent_char(input logic [2:0] e, input logic [2:0] i);
        logic [39:0] text;
        unique case (e)
            3'd0:    text = {8'h00, 8'h00, ";", "t", "l"};
            3'd1:    text = {8'h00, 8'h00, ";", "t", "g"};
            3'd2:    text = {8'h00, ";", "p", "m", "a"};
            3'd3:    text = {";", "t", "o", "u", "q"};
            3'd4:    text = {";", "s", "o", "p", "a"};
            3'd5:    text = {";", "p", "s", "b", "n"};
            default: text = '0;
        endcase
        unique case (i)
            3'd0:    ent_char = text[7:0];
            3'd1:    ent_char = text[15:8];
            3'd2:    ent_char = text[23:16];
            3'd3:    ent_char = text[31:24];
            3'd4:    ent_char = text[39:32];
            default: ent_char = 8'h00;
        endcase
    endfunction

    // Number of characters of named entity e after the '&'.
    function automatic logic [2:0] ent_len(input logic [2:0] e);
        unique case (e)
            3'd0, 3'd1: ent_len = 3'd3;
            3'd2:       ent_len = 3'd4;
            default:    ent_len = 3'd5;
        endcase
    endfunction

    // Decoded byte of named entity e.
    function automatic logic [7:0] ent_code(input logic [2:0] e);
        unique case (e)
            3'd0:    ent_code = 8'h3C;
            3'd1:    ent_code = 8'h3E;
            3'd2:    ent_code = 8'h26;
            3'd3:    ent_code = 8'h22;
            3'd4:    ent_code = 8'h27;
            default: ent_code = 8'h20;
        endcase
    endfunction

endpackage

// ===== src/hed_core.sv =====
`timescale 1ns / 1ps
// Decoder core: entity match state and the single-pass logic that turns one
// input byte into a burst of result bytes. Depends on hed_pkg.
module hed_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  hed_pkg::item_t  item,
    input  logic            take,
    output hed_pkg::burst_t burst
);
    import hed_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NAMED  = 4'b0010,
        MODE_HASH   = 4'b0100,
        MODE_DIGITS = 4'b1000
    } mode_t;

    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [8:0] NUM_SAT    = 9'd256;

    // Byte for a numeric entity value: the value itself when 1 to 255, else '?'.
    function automatic logic [7:0] value_byte(input logic [8:0] v);
        value_byte = (!v[8] && (v[7:0] != 8'h00)) ? v[7:0] : CHAR_QMARK;
    endfunction

    mode_t                         mode_reg, mode_next;
    logic [HELD_DEPTH-1:0][7:0]    held_reg, held_next;
    logic [COUNT_W-1:0]            cnt_reg, cnt_next;
    logic [8:0]                    num_reg, num_next;

    logic [7:0]                    b;
    logic                          is_digit;
    logic [11:0]                   acc;
    logic [8:0]                    acc_sat;
    logic [2:0]                    k;
    logic                          same;
    logic                          hit;
    logic                          full_hit;
    logic                          prefix_hit;
    logic [7:0]                    full_code;
    logic [COUNT_W-1:0]            pre_cnt;
    logic                          pre_value;
    logic                          mid_v;
    logic [7:0]                    mid_b;
    logic                          idle_go;
    mode_t                         mode_proc;
    logic [COUNT_W-1:0]            cnt_proc;
    logic [8:0]                    num_proc;
    logic [COUNT_W-1:0]            post_cnt;
    logic [MAX_OUT-1:0][7:0]       pre_b;
    logic [MAX_OUT-1:0][7:0]       post_b;

    assign b        = item.data;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

    // Saturating decimal accumulate; the digit is the low nibble of its ASCII code.
    assign acc     = 12'(num_reg) * 12'd10 + {8'h00, b[3:0]};
    assign acc_sat = (acc > 12'(NUM_SAT)) ? NUM_SAT : acc[8:0];

    // Named entity match of the new byte against all entities at once.
    assign k = (cnt_reg == '0) ? 3'd0 : 3'(cnt_reg - 1'b1);

    always_comb begin
        full_hit   = 1'b0;
        prefix_hit = 1'b0;
        full_code  = 8'h00;
        same       = 1'b0;
        hit        = 1'b0;
        for (int e = 0; e < ENT_COUNT; e++) begin
            same = (k < ent_len(3'(e)));
            for (int i = 0; i < HELD_DEPTH - 1; i++) begin
                if ((3'(i) < k) && (held_reg[i+1] != ent_char(3'(e), 3'(i)))) begin
                    same = 1'b0;
                end
            end
            hit = same && (ent_char(3'(e), k) == b);
            if (hit && (3'(k + 3'd1) == ent_len(3'(e)))) begin
                full_hit  = 1'b1;
                full_code = ent_code(3'(e));
            end else if (hit) begin
                prefix_hit = 1'b1;
            end
        end
    end

    // Processing of the byte in the current mode.
    always_comb begin
        mode_proc = mode_reg;
        cnt_proc  = cnt_reg;
        num_proc  = num_reg;
        held_next = held_reg;
        pre_cnt   = '0;
        pre_value = 1'b0;
        mid_v     = 1'b0;
        mid_b     = b;
        idle_go   = 1'b0;
        unique case (mode_reg)
            MODE_NAMED: begin
                if (full_hit) begin
                    mode_proc = MODE_IDLE;
                    cnt_proc  = '0;
                    mid_v     = 1'b1;
                    mid_b     = full_code;
                end else if (prefix_hit) begin
                    for (int j = 0; j < HELD_DEPTH; j++) begin
                        if (cnt_reg == COUNT_W'(j)) begin
                            held_next[j] = b;
                        end
                    end
                    cnt_proc = COUNT_W'(cnt_reg + 1'b1);
                end else if ((k == 3'd0) && (b == CHAR_HASH)) begin
                    held_next[1] = b;
                    cnt_proc     = COUNT_W'(2);
                    mode_proc    = MODE_HASH;
                end else begin
                    pre_cnt = cnt_reg;
                    idle_go = 1'b1;
                end
            end
            MODE_HASH: begin
                if (is_digit) begin
                    num_proc  = {5'b0, b[3:0]};
                    cnt_proc  = '0;
                    mode_proc = MODE_DIGITS;
                end else begin
                    pre_cnt = cnt_reg;
                    idle_go = 1'b1;
                end
            end
            MODE_DIGITS: begin
                if (is_digit) begin
                    num_proc = acc_sat;
                end else begin
                    pre_cnt   = COUNT_W'(1);
                    pre_value = 1'b1;
                    num_proc  = '0;
                    mode_proc = MODE_IDLE;
                    idle_go   = (b != CHAR_SEMI);
                end
            end
            default: begin
                idle_go = 1'b1;
            end
        endcase

        // Idle handling: an '&' opens a named match, anything else passes through.
        if (idle_go) begin
            if (b == CHAR_AMP) begin
                held_next[0] = b;
                cnt_proc     = COUNT_W'(1);
                mode_proc    = MODE_NAMED;
            end else begin
                mid_v     = 1'b1;
                mid_b     = b;
                cnt_proc  = '0;
                mode_proc = MODE_IDLE;
            end
        end
    end

    // End of text flushes whatever the byte left pending.
    always_comb begin
        post_cnt = '0;
        post_b   = '0;
        if (item.last) begin
            if (mode_proc == MODE_DIGITS) begin
                post_cnt  = COUNT_W'(1);
                post_b[0] = value_byte(num_proc);
            end else if (mode_proc != MODE_IDLE) begin
                post_cnt = cnt_proc;
                for (int j = 0; j < HELD_DEPTH; j++) begin
                    post_b[j] = held_next[j];
                end
            end
        end
        if (item.last) begin
            mode_next = MODE_IDLE;
            cnt_next  = '0;
            num_next  = '0;
        end else begin
            mode_next = mode_proc;
            cnt_next  = cnt_proc;
            num_next  = num_proc;
        end
    end

    // Slot assembly: released bytes, then the decoded byte, then the flush.
    // A flush that follows released or decoded bytes is always a lone '&'.
    always_comb begin
        pre_b = '0;
        for (int j = 0; j < HELD_DEPTH; j++) begin
            pre_b[j] = held_reg[j];
        end
        if (pre_value) begin
            pre_b[0] = value_byte(num_reg);
        end
        for (int j = 0; j < MAX_OUT; j++) begin
            if (COUNT_W'(j) < pre_cnt) begin
                burst.bytes[j] = pre_b[j];
            end else if (mid_v && (COUNT_W'(j) == pre_cnt)) begin
                burst.bytes[j] = mid_b;
            end else if ((pre_cnt == '0) && !mid_v) begin
                burst.bytes[j] = post_b[j];
            end else begin
                burst.bytes[j] = CHAR_AMP;
            end
        end
        burst.count = COUNT_W'(pre_cnt + {2'b00, mid_v} + post_cnt);
        burst.last  = item.last;
    end

    // Match state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            num_reg  <= '0;
        end else if (take) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
        end
    end

    // Held bytes carry no reset; only entries below the count are read.
    always_ff @(posedge aclk) begin
        if (take) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/hed_out_buf.sv =====
`timescale 1ns / 1ps
// Result buffer: holds one burst of decoded bytes and sends it out one
// transaction per cycle while m_tready is high. Depends on hed_pkg.
module hed_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  hed_pkg::burst_t burst,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tlast    // out_last
);
    import hed_pkg::*;

    logic                    valid_reg;
    logic [MAX_OUT-1:0][7:0] bytes_reg;
    logic [COUNT_W-1:0]      cnt_reg;
    logic [COUNT_W-1:0]      idx_reg;
    logic                    last_reg;
    logic                    final_beat;

    // The buffer frees up in the same cycle its final byte is taken.
    assign final_beat = (idx_reg == COUNT_W'(cnt_reg - 1'b1));
    assign free       = !valid_reg || (m_tready && final_beat);

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = last_reg && final_beat;

    // Control: load a new burst or step through the current one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (final_beat) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= COUNT_W'(idx_reg + 1'b1);
            end
        end
    end

    // Burst payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
            cnt_reg   <= burst.count;
            last_reg  <= burst.last;
        end
    end

endmodule

// ===== src/html_entity_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the HTML entity decoder: input register, decoder core and
// result buffer. Depends on hed_pkg, hed_core and hed_out_buf.
//
//  Channel  | Direction | tdata          | tlast
//  ---------+-----------+----------------+------------
//  s_       | in        | text_byte[7:0] | end_of_text
//  m_       | out       | out_byte[7:0]  | out_last
//
// Each input byte is decoded in one pass between the input register and the
// result buffer. While m_tready is high, a byte yielding one result sustains
// one transaction per cycle; a byte that releases held bytes yields up to six
// results, sent one per cycle; the input waits as the result buffer drains.
// Reset (aresetn low, synchronous) clears the match state and empties both
// registers. Input is taken while the downstream side stalls until both fill.
module html_entity_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // text_byte[7:0]
    input  logic       s_tlast,    // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte[7:0]
    output logic       m_tlast     // out_last
);
    import hed_pkg::*;

    logic            in_valid_reg;
    item_t           in_item_reg;
    burst_t          burst;
    logic            buf_free;
    logic            take;
    logic            load;

    // The registered byte is decoded once the result buffer can take its burst.
    assign take     = in_valid_reg && ((burst.count == '0) || buf_free);
    assign load     = take && (burst.count != '0);
    assign s_tready = !in_valid_reg || take;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data <= s_tdata;
            in_item_reg.last <= s_tlast;
        end
    end

    hed_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .take    (take),
        .burst   (burst)
    );

    hed_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst    (burst),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
